FILE: hw/rtl/stli_pkg.sv
package stli_pkg;

   localparam int TableDepth = 256;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = IdxW + 1;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_INS_DEC,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INS_WR,
      S_Q_RD_UP,
      S_Q_RD_LO,
      S_Q_PREP,
      S_MUL,
      S_DIV,
      S_DONE
   } state_type;

   // datapath command
   typedef struct packed {
      logic load;        // capture request, reset search bounds
      logic rd_mid;      // read entry at search midpoint
      logic step_search; // narrow bounds from read entry
      logic rd_up;       // read entry at lower bound
      logic rd_lo;       // read entry at lower bound - 1
      logic rd_shift;    // read entry at shift pointer - 1
      logic wr_shift;    // write read entry at shift pointer, decrement
      logic wr_new;      // write new point at lower bound, count++
      logic prep;        // form operands for interpolation
      logic mul;         // product
      logic div_step;    // one quotient bit
      logic finish;      // form response
      status_type st;    // status for finish
      logic use_value;   // response value from interpolation
   } cmd_ctl_type;

   typedef struct packed {
      logic search_done;
      logic found_dup;
      logic table_full;
      logic table_empty;
      logic shift_done;
      logic div_done;
      logic endpoint;    // query answered by a stored y: end point or exact hit
   } dp_stat_type;

endpackage

FILE: hw/rtl/stli_datapath.sv
module stli_datapath
   import stli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_in,
   input  cmd_ctl_type ctl,
   output dp_stat_type stat,
   output rsp_type     rsp_out
);

   logic signed [31:0] x_mem [TableDepth];
   logic signed [31:0] y_mem [TableDepth];

   req_type            req_ff;
   logic [CntW-1:0]    count_ff, lo_ff, hi_ff, ptr_ff;
   logic signed [31:0] rx_ff, ry_ff;
   logic signed [31:0] xu_ff, yu_ff, y0_ff;
   logic [32:0]        dx_ff, off_ff, mag_ff;
   logic               neg_ff;
   logic [65:0]        prod_ff;
   logic [65:0]        rem_ff;
   logic [65:0]        quo_ff;
   logic [6:0]         bit_ff;
   logic               ep_ff;
   rsp_type            rsp_ff;

   logic [CntW-1:0] mid;
   logic [IdxW-1:0] rd_addr, wr_addr;
   logic            wr_en;
   logic signed [31:0] wr_x, wr_y;
   logic [66:0]     trial;
   logic signed [34:0] sum;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      rd_addr = mid[IdxW-1:0];
      if (ctl.rd_up) rd_addr = lo_ff[IdxW-1:0];
      if (ctl.rd_lo) rd_addr = IdxW'(lo_ff - 1'b1);
      if (ctl.rd_shift) rd_addr = IdxW'(ptr_ff - 1'b1);
   end

   always_comb begin
      wr_en   = ctl.wr_shift | ctl.wr_new;
      wr_addr = ptr_ff[IdxW-1:0];
      wr_x    = rx_ff;
      wr_y    = ry_ff;
      if (ctl.wr_new) begin
         wr_addr = lo_ff[IdxW-1:0];
         wr_x    = req_ff.coord_x;
         wr_y    = req_ff.coord_y;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff <= x_mem[rd_addr];
      ry_ff <= y_mem[rd_addr];
      if (wr_en) begin
         x_mem[wr_addr] <= wr_x;
         y_mem[wr_addr] <= wr_y;
      end
   end

   assign trial = {rem_ff, prod_ff[65]} - {34'd0, dx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.wr_new) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_in;
         lo_ff  <= '0;
         hi_ff  <= count_ff;
         ptr_ff <= count_ff;
         ep_ff  <= 1'b0;
      end
      if (ctl.step_search) begin
         // rx_ff holds entry at mid from previous cycle; mid unchanged since
         if (rx_ff < req_ff.coord_x) lo_ff <= mid + 1'b1;
         else hi_ff <= mid;
      end
      if (ctl.wr_shift) ptr_ff <= ptr_ff - 1'b1;
      if (ctl.rd_up) begin
         // answered by an end point when bound is at either end
         ep_ff <= (lo_ff == '0) || (lo_ff == count_ff);
      end
      if (ctl.rd_lo) begin
         xu_ff <= rx_ff;
         yu_ff <= ry_ff;
      end
      if (ctl.prep) begin
         y0_ff  <= ry_ff;
         dx_ff  <= 33'(xu_ff) - 33'(rx_ff);
         off_ff <= 33'(req_ff.coord_x) - 33'(rx_ff);
         neg_ff <= yu_ff < ry_ff;
         mag_ff <= (yu_ff < ry_ff) ? 33'(ry_ff) - 33'(yu_ff) : 33'(yu_ff) - 33'(ry_ff);
         // exact hit on upper point: its y is the answer
         if (xu_ff == req_ff.coord_x) ep_ff <= 1'b1;
      end
      if (ctl.mul) begin
         prod_ff <= 66'(mag_ff) * 66'(off_ff);
         rem_ff  <= '0;
         quo_ff  <= '0;
         bit_ff  <= 7'd66;
      end
      if (ctl.div_step) begin
         if (!trial[66]) begin
            rem_ff <= trial[65:0];
            quo_ff <= {quo_ff[64:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[64:0], prod_ff[65]};
            quo_ff <= {quo_ff[64:0], 1'b0};
         end
         prod_ff <= {prod_ff[64:0], 1'b0};
         bit_ff  <= bit_ff - 1'b1;
      end
      if (ctl.finish) begin
         rsp_ff.status <= ctl.st;
         // past the last point the answer is the lower neighbor's y
         if (!ctl.use_value) rsp_ff.value <= '0;
         else if (ep_ff) rsp_ff.value <= (lo_ff == count_ff) ? y0_ff : yu_ff;
         else if (sum > 35'sd2147483647) rsp_ff.value <= 32'sh7fffffff;
         else if (sum < -35'sd2147483648) rsp_ff.value <= 32'sh80000000;
         else rsp_ff.value <= sum[31:0];
      end
   end

   // quotient is below 2^33 since it lies within |dy|
   assign sum = neg_ff ? 35'(y0_ff) - 35'(quo_ff[33:0]) : 35'(y0_ff) + 35'(quo_ff[33:0]);

   assign stat.search_done = lo_ff >= hi_ff;
   assign stat.found_dup   = (lo_ff < count_ff) && (rx_ff == req_ff.coord_x);
   assign stat.table_full  = count_ff == CntW'(TableDepth);
   assign stat.table_empty = count_ff == '0;
   assign stat.shift_done  = ptr_ff == lo_ff;
   assign stat.div_done    = bit_ff == '0;
   assign stat.endpoint    = ep_ff;
   assign rsp_out          = rsp_ff;

endmodule

FILE: hw/rtl/stli_ctrl.sv
module stli_ctrl
   import stli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_query,
   input  dp_stat_type stat,
   output cmd_ctl_type ctl,
   output logic        busy,
   output logic        done
);

   state_type  state_ff, state_in;
   status_type st_ff, st_in;
   logic       val_ff, val_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_OK;
         val_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
         val_ff   <= val_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      val_in   = val_ff;
      ctl      = '0;
      ctl.st   = st_ff;
      ctl.use_value = val_ff;
      busy     = state_ff != S_IDLE;
      done     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               st_in    = ST_OK;
               val_in   = 1'b0;
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            if (stat.search_done) begin
               ctl.rd_up = 1'b1;
               state_in  = is_query ? S_Q_RD_UP : S_INS_DEC;
            end else begin
               ctl.rd_mid = 1'b1;
               state_in   = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            ctl.step_search = 1'b1;
            state_in = S_SRCH_RD;
         end
         S_INS_DEC: begin
            if (stat.found_dup) begin
               st_in    = ST_DUP;
               state_in = S_DONE;
            end else if (stat.table_full) begin
               st_in    = ST_FULL;
               state_in = S_DONE;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.shift_done) begin
               state_in = S_INS_WR;
            end else begin
               ctl.rd_shift = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            ctl.wr_shift = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_INS_WR: begin
            ctl.wr_new = 1'b1;
            state_in   = S_DONE;
         end
         S_Q_RD_UP: begin
            if (stat.table_empty) begin
               st_in    = ST_EMPTY;
               state_in = S_DONE;
            end else begin
               ctl.rd_lo = 1'b1;
               val_in    = 1'b1;
               state_in  = S_Q_RD_LO;
            end
         end
         S_Q_RD_LO: begin
            ctl.prep = 1'b1;
            state_in = S_Q_PREP;
         end
         S_Q_PREP: begin
            state_in = stat.endpoint ? S_DONE : S_MUL;
         end
         S_MUL: begin
            ctl.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_DONE;
            end else begin
               ctl.div_step = 1'b1;
            end
         end
         S_DONE: begin
            ctl.finish = 1'b1;
            state_in   = S_IDLE;
            done       = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/sorted_table_linear_interpolator.sv
// Each item bisects the table (at most ceil(log2(count+1)) probes, each a read and a
// compare on the one read port). An insert stops on a duplicate or full table, else
// shifts the entries above up and writes the point. A query stops on an empty table,
// takes a stored y at an end point or exact hit, else multiplies, then divides one
// bit per cycle over 66 bits. One item at a time; busy drops in the strobe cycle.
// Synchronous reset empties the table, entries are not cleared; receiver cannot stall.
module sorted_table_linear_interpolator
   import stli_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   cmd_ctl_type ctl;
   dp_stat_type stat;
   logic        done;
   logic        strobe_ff;
   logic        query_ff;

   // remember the command of the item in flight
   always_ff @(posedge clock) begin
      if (start && !busy) query_ff <= (req_item.cmd == CMD_QUERY);
   end

   stli_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .is_query (query_ff),
      .stat     (stat),
      .ctl      (ctl),
      .busy     (busy),
      .done     (done)
   );

   stli_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_item),
      .ctl     (ctl),
      .stat    (stat),
      .rsp_out (rsp_item)
   );

   // response register loads on the finish cycle; strobe is registered alongside it
   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= done;
   end

   assign rsp_strobe = strobe_ff;

endmodule

FILE: tb/testbench.sv
module testbench;
   import stli_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   sorted_table_linear_interpolator uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   localparam longint QMIN = -64'sd2147483648;
   localparam longint QMAX = 64'sd2147483647;
   localparam int WATCHDOG_LIMIT = 5000;

   // Shadow copy of the point table, kept sorted by x like the block's own.
   longint shadow_x [TableDepth];
   longint shadow_y [TableDepth];
   int     shadow_count;

   rsp_type pending_rsp [$];
   int      error_count;
   int      insert_count, query_count, rsp_count;
   int      idle_cycles;
   bit      idle_enable;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // First slot whose x is not below key; shadow_count if none.
   function automatic int lower_slot(longint key);
      int lo, hi, mid;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_x[mid] < key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic longint interp_at(longint x);
      int          last, up, lo;
      longint      dx, dy, off, r;
      logic [127:0] mag, prod, quot;
      last = shadow_count - 1;
      if (x <= shadow_x[0]) return shadow_y[0];
      if (x >= shadow_x[last]) return shadow_y[last];
      up = lower_slot(x);
      lo = up - 1;
      dx = shadow_x[up] - shadow_x[lo];
      dy = shadow_y[up] - shadow_y[lo];
      off = x - shadow_x[lo];
      mag = (dy < 0) ? -dy : dy;
      prod = mag * off;
      quot = prod / dx;
      r = (dy < 0) ? shadow_y[lo] - longint'(quot) : shadow_y[lo] + longint'(quot);
      if (r > QMAX) r = QMAX;
      if (r < QMIN) r = QMIN;
      return r;
   endfunction

   // Apply one item to the shadow table and return the response it earns.
   function automatic rsp_type apply_item(req_type r);
      rsp_type res;
      longint  x, y, v;
      int      pos;
      x = longint'(r.coord_x);
      y = longint'(r.coord_y);
      res.value = '0;
      res.status = ST_OK;
      if (r.cmd == CMD_INSERT) begin
         pos = lower_slot(x);
         if (pos < shadow_count && shadow_x[pos] == x) begin
            res.status = ST_DUP;
         end else if (shadow_count >= TableDepth) begin
            res.status = ST_FULL;
         end else begin
            for (int i = shadow_count; i > pos; i--) begin
               shadow_x[i] = shadow_x[i-1];
               shadow_y[i] = shadow_y[i-1];
            end
            shadow_x[pos] = x;
            shadow_y[pos] = y;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         res.status = ST_EMPTY;
      end else begin
         v = interp_at(x);
         res.value = v[31:0];
      end
      return res;
   endfunction

   // Hold start low for a random burst now and then.
   task automatic maybe_idle();
      int n;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Present one item and hold it until the block takes it. Start stays high on
   // return so back-to-back items never lower and raise it in one step.
   task automatic send_item(cmd_type cmd, logic [31:0] x, logic [31:0] y);
      req_type r;
      r.cmd = cmd;
      r.coord_x = x;
      r.coord_y = y;
      maybe_idle();
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      pending_rsp = {pending_rsp, apply_item(r)};
      if (cmd == CMD_INSERT) insert_count++;
      else query_count++;
   endtask

   // Pause the sender until every outstanding response has arrived.
   task automatic drain_pending();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Compare each response with the oldest outstanding prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            $error("response with nothing outstanding: value %0d status %0d",
                   rsp_item.value, rsp_item.status);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_item.value);
               error_count++;
            end
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               error_count++;
            end
         end
      end
   end

   // Stop the run if neither side makes progress for too long.
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without progress", idle_cycles);
            $display("testbench failed");
            $finish;
         end
      end
   end

   // Empty table, single point, end points, exact hits, duplicates and steep
   // interpolation across the whole signed range.
   task automatic test_directed();
      send_item(CMD_QUERY, 32'h0000_1234, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'h0001_0000, 32'h0005_0000);
      send_item(CMD_QUERY, 32'h8000_0000, 32'h0);
      send_item(CMD_QUERY, 32'h7FFF_FFFF, 32'h0);
      send_item(CMD_QUERY, 32'h0001_0000, 32'h0);
      send_item(CMD_INSERT, 32'h0001_0000, 32'h1111_1111);
      send_item(CMD_INSERT, 32'h8000_0000, 32'h8000_0000);
      send_item(CMD_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(CMD_INSERT, 32'h0000_0000, 32'h7FFF_FFFF);
      send_item(CMD_QUERY, 32'h8000_0000, 32'h0);
      send_item(CMD_QUERY, 32'h7FFF_FFFF, 32'h0);
      send_item(CMD_QUERY, 32'hC000_0000, 32'hFFFF_FFFF);
      send_item(CMD_QUERY, 32'h8000_0001, 32'h0);
      send_item(CMD_QUERY, 32'hFFFF_FFFF, 32'h0);
      send_item(CMD_QUERY, 32'h0000_8000, 32'h0);
      send_item(CMD_QUERY, 32'h4000_0000, 32'h0);
      send_item(CMD_QUERY, 32'h7FFF_FFFE, 32'h0);
      send_item(CMD_INSERT, 32'h7FFF_FFFF, 32'h0);
      send_item(CMD_INSERT, 32'h8000_0000, 32'h0);
      send_item(CMD_QUERY, 32'h0000_0000, 32'h0);
      drain_pending();
   endtask

   // Mostly queries near stored points and fresh inserts; some duplicates and
   // wide random positions.
   task automatic test_random();
      int          pick, k;
      logic [31:0] x;
      for (int n = 0; n < 220; n++) begin
         if (n == 110) drain_pending();
         pick = $urandom_range(0, 9);
         k = $urandom_range(0, shadow_count - 1);
         case (pick)
            0, 1, 2: begin
               send_item(CMD_INSERT, $urandom(), $urandom());
            end
            3: begin
               x = shadow_x[k][31:0];
               send_item(CMD_INSERT, x, $urandom());
            end
            4: begin
               x = shadow_x[k][31:0];
               send_item(CMD_QUERY, x, $urandom());
            end
            5, 6: begin
               x = shadow_x[k][31:0] + $urandom_range(0, 65536) - 32768;
               send_item(CMD_QUERY, x, $urandom());
            end
            default: begin
               send_item(CMD_QUERY, $urandom(), $urandom());
            end
         endcase
      end
   endtask

   // Fill the table, then hit the full and duplicate-while-full cases.
   // No idling in this last stretch.
   task automatic test_full_table();
      idle_enable = 1'b0;
      while (shadow_count < TableDepth) send_item(CMD_INSERT, $urandom(), $urandom());
      send_item(CMD_INSERT, shadow_x[7][31:0], 32'h0);
      send_item(CMD_INSERT, $urandom(), $urandom());
      send_item(CMD_INSERT, shadow_x[TableDepth-1][31:0] + 1, 32'h0);
      for (int n = 0; n < 20; n++) send_item(CMD_QUERY, $urandom(), $urandom());
      start <= 1'b0;
   endtask

   initial begin
      int guard;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      shadow_count = 0;
      insert_count = 0;
      query_count = 0;
      idle_enable = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random();
      test_full_table();

      // Wait out outstanding responses, then allow for any stray strobe.
      guard = 0;
      while (pending_rsp.size() != 0 && guard < WATCHDOG_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);

      $display("covered %0d inserts and %0d queries, %0d responses checked",
               insert_count, query_count, rsp_count);
      $display("table ended with %0d points, through empty, duplicate and full cases",
               shadow_count);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
